// ===== hw/rtl/water_shore_marking_stencil_defines.svh =====
// Assertion macros shared by the shore marking stencil RTL.
`ifndef WATER_SHORE_MARKING_STENCIL_DEFINES_SVH
`define WATER_SHORE_MARKING_STENCIL_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define WSMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define WSMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/wsms_pkg.sv =====
// Types, constants and the shore marking function of the stencil.
`timescale 1ns / 1ps

package wsms_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_RESET      = 64;
  localparam int CFG_DW         = 11;
  localparam int CFG_AW         = 1;

  typedef logic [2:0] label_t;

  localparam label_t LBL_WATER = 3'd2;
  localparam label_t LBL_SAND  = 3'd4;

  typedef enum logic [CFG_AW-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_e;

  // window[row][col], row 0 is the oldest row, col 2 the newest column
  typedef label_t [2:0][2:0] win_t;

  typedef struct packed {
    logic emit_edge;  // right edge tile, uses window before the shift
    logic emit_mid;   // centre of the shifted window
    logic left_ok;
    logic up_ok;
    logic down_ok;
    logic last;
  } stage_ctl_t;

  // Tile becomes sand if it is not water and any in-map neighbour is water.
  function automatic label_t shore_mark(win_t win, logic ctr_right, logic left_ok,
                                        logic right_ok, logic up_ok, logic down_ok);
    int     cc;
    int     col;
    logic   wet;
    label_t ctr;
    cc  = ctr_right ? 2 : 1;
    wet = 1'b0;
    ctr = win[1][cc];
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        col = cc + dc;
        if ((dr == 0 && !up_ok) || (dr == 2 && !down_ok)) continue;
        if (dr == 1 && dc == 0) continue;
        if ((dc < 0 && !left_ok) || (dc > 0 && !right_ok)) continue;
        if (col < 0 || col > 2) continue;
        if (win[dr][col] == LBL_WATER) wet = 1'b1;
      end
    end
    if (ctr == LBL_WATER) return ctr;
    return wet ? LBL_SAND : ctr;
  endfunction

endpackage

// ===== hw/rtl/water_shore_marking_stencil.sv =====
// Shore marking 3x3 stencil over a raster tile label stream.
//
// Input stream: one tile label per word in raster order (x fastest). tuser[0]
// marks a drain word that carries no tile; drain words are dropped while the
// map is still coming in and flush the pending results after its last tile.
// Output stream: one marked label per word, tlast on the final tile of the map.
// A non-water tile next to water (8-neighbourhood, inside the map) becomes sand.
// Results trail their tile by one map row plus one word; after the map,
// width + 1 further words of any kind (their labels are dropped) push out the
// remaining results.
// Configuration: map width and height through cfg_we_i/cfg_addr_i/cfg_wdata_i,
// written while idle; a write restarts the map. Width or height 0 acts as 1,
// values above the maximum act as the maximum.
// Throughput is one word per cycle while the receiver takes results. A word is
// registered in the line store read stage, then in the output register, which
// drives tvalid.
// The two line stores share one memory, read at accept, written one stage later.
// Reset clears counters, window and valids; the line store is not cleared.
// A stalled receiver holds the output register; the read stage then stalls
// and tready drops, no word is lost.
`timescale 1ns / 1ps

`include "water_shore_marking_stencil_defines.svh"

module water_shore_marking_stencil #(
  parameter int MAX_WIDTH  = wsms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wsms_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wsms_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [wsms_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [2:0] tile_label
  input  logic [0:0]                  s_axis_tuser,   // [0] drain
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [2:0] result_label
  output logic                        m_axis_tlast
);
  import wsms_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam logic [WW-1:0] W_RST = WW'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
  localparam logic [HW-1:0] H_RST = HW'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

  logic [WW-1:0] w_q, w_d;
  logic [HW-1:0] h_q, h_d;
  logic [CW-1:0] c_q, c_d;
  logic [RW-1:0] r_q, r_d;
  logic [31:0]   cfg_wide;
  logic          restart;

  logic          in_acc, take, adv, emit;
  logic          r_lt_h, c_end;
  label_t        n_in;
  stage_ctl_t    ctl_in;

  logic          s1_valid_q, s1_valid_d;
  stage_ctl_t    s1_ctl_q;
  label_t        s1_n_q;
  logic [CW-1:0] s1_k_q;
  logic          s1_byp_q;
  logic [5:0]    s1_byp_data_q;

  logic [5:0]    mem [MAX_WIDTH];
  logic [5:0]    rd_q;
  logic [5:0]    ent;
  logic [5:0]    wr_data;

  win_t          win_q, win_d, win_sh;
  label_t        res;

  logic          out_valid_q, out_valid_d;
  label_t        out_label_q;
  logic          out_last_q;

  // configuration
  assign cfg_wide = 32'(cfg_wdata_i);
  assign restart  = cfg_we_i;

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_MAP_WIDTH: begin
          if (cfg_wide == 32'd0) w_d = WW'(1);
          else if (cfg_wide > 32'(MAX_WIDTH)) w_d = WW'(MAX_WIDTH);
          else w_d = WW'(cfg_wide);
        end
        REG_MAP_HEIGHT: begin
          if (cfg_wide == 32'd0) h_d = HW'(1);
          else if (cfg_wide > 32'(MAX_HEIGHT)) h_d = HW'(MAX_HEIGHT);
          else h_d = HW'(cfg_wide);
        end
        default: begin
          w_d = w_q;
        end
      endcase
    end
  end

  // input side: position counters and per-word control
  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign r_lt_h = r_q < RW'(h_q);
  assign c_end  = (WW'(c_q) + WW'(1)) == w_q;
  assign take   = in_acc && !(r_lt_h && s_axis_tuser[0]);
  assign n_in   = r_lt_h ? s_axis_tdata[2:0] : label_t'(0);

  always_comb begin
    ctl_in.emit_edge = (c_q == '0) && (r_q > RW'(1));
    ctl_in.emit_mid  = (c_q != '0) && (r_q != '0) && (r_q <= RW'(h_q));
    ctl_in.last      = (c_q == '0) && (r_q == RW'(h_q) + RW'(1));
    if (c_q == '0) begin
      ctl_in.left_ok = w_q > WW'(1);
      ctl_in.up_ok   = r_q > RW'(2);
      ctl_in.down_ok = r_q <= RW'(h_q);
    end else begin
      ctl_in.left_ok = c_q > CW'(1);
      ctl_in.up_ok   = r_q > RW'(1);
      ctl_in.down_ok = r_lt_h;
    end
  end

  always_comb begin
    c_d = c_q;
    r_d = r_q;
    priority if (restart) begin
      c_d = '0;
      r_d = '0;
    end else if (take) begin
      if (ctl_in.last) begin
        c_d = '0;
        r_d = '0;
      end else if (c_end) begin
        c_d = '0;
        r_d = r_q + RW'(1);
      end else begin
        c_d = c_q + CW'(1);
      end
    end else begin
      c_d = c_q;
      r_d = r_q;
    end
  end

  // line store: [5:3] middle row, [2:0] upper row
  assign ent     = s1_byp_q ? s1_byp_data_q : rd_q;
  assign wr_data = {s1_n_q, ent[5:3]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mem[s1_k_q] <= wr_data;
    end
    if (take) begin
      rd_q <= mem[c_q];
    end
  end

  // window and result
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_sh[k][0] = win_q[k][1];
      win_sh[k][1] = win_q[k][2];
    end
    win_sh[0][2] = ent[2:0];
    win_sh[1][2] = ent[5:3];
    win_sh[2][2] = s1_n_q;
  end

  always_comb begin
    if (s1_ctl_q.emit_edge) begin
      res = shore_mark(win_q, 1'b1, s1_ctl_q.left_ok, 1'b0, s1_ctl_q.up_ok,
                       s1_ctl_q.down_ok);
    end else begin
      res = shore_mark(win_sh, 1'b0, s1_ctl_q.left_ok, 1'b1, s1_ctl_q.up_ok,
                       s1_ctl_q.down_ok);
    end
  end

  assign emit = s1_ctl_q.emit_edge || s1_ctl_q.emit_mid;

  always_comb begin
    win_d = win_q;
    priority if (restart) begin
      win_d = '0;
    end else if (adv) begin
      win_d = s1_ctl_q.last ? '0 : win_sh;
    end else begin
      win_d = win_q;
    end
  end

  assign s1_valid_d  = take || (s1_valid_q && !adv);
  assign out_valid_d = (adv && emit) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= W_RST;
      h_q         <= H_RST;
      c_q         <= '0;
      r_q         <= '0;
      win_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_ctl_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      w_q         <= w_d;
      h_q         <= h_d;
      c_q         <= c_d;
      r_q         <= r_d;
      win_q       <= win_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (take) begin
        s1_ctl_q <= ctl_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_n_q        <= n_in;
      s1_k_q        <= c_q;
      // same address written this cycle (one tile per row): forward it
      s1_byp_q      <= adv && (s1_k_q == c_q);
      s1_byp_data_q <= wr_data;
    end
    if (adv && emit) begin
      out_label_q <= res;
      out_last_q  <= s1_ctl_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_label_q};
  assign m_axis_tlast  = out_last_q;

  `WSMS_ASSERT(a_stall_needs_stage, !s_axis_tready |-> s1_valid_q, "tready low without stage")
  `WSMS_ASSERT(a_one_emit, s1_valid_q |-> !(s1_ctl_q.emit_edge && s1_ctl_q.emit_mid),
               "two results for one word")
  `WSMS_ASSERT(a_last_on_edge, s1_valid_q && s1_ctl_q.last |-> s1_ctl_q.emit_edge,
               "last tile not on right edge")
  `WSMS_ASSERT_ALWAYS(a_col_bound, !rst_ni || (WW'(c_q) < w_q), "column beyond map width")
  `WSMS_ASSERT(a_row_bound, r_q <= RW'(h_q) + RW'(1), "row beyond map height plus one")

endmodule

// ===== tb/tb_top.sv =====
// Testbench of the shore marking stencil: tile map predictor, stream drivers and stimulus.
`timescale 1ns / 1ps

module tb_top;
  import wsms_pkg::*;

  class shore_scoreboard;
    typedef struct packed {
      label_t lbl;
      logic   last;
    } tile_res_t;

    bit [CFG_DW-1:0] width_reg;
    bit [CFG_DW-1:0] height_reg;
    label_t          upper_line[MAX_WIDTH_DEF];
    label_t          middle_line[MAX_WIDTH_DEF];
    label_t          win[3][3];
    int unsigned     in_col;
    int unsigned     in_row;
    int unsigned     out_col;
    int unsigned     out_row;
    tile_res_t       expected_tiles[$];
    int unsigned     fail_count;

    function new();
      width_reg  = CFG_DW'(DIM_RESET);
      height_reg = CFG_DW'(DIM_RESET);
      fail_count = 0;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      restart_map();
    endfunction

    static function int unsigned eff_dim(bit [CFG_DW-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void restart_map();
      foreach (win[i, j]) win[i][j] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void set_reg(reg_idx_e idx, bit [CFG_DW-1:0] value);
      if (idx == REG_MAP_WIDTH) width_reg = value;
      else height_reg = value;
      restart_map();
    endfunction

    // centre at column ccol of the middle window row
    function label_t shore_label(int ccol, bit left_ok, bit right_ok, bit up_ok, bit down_ok);
      label_t ctr;
      bit     wet;
      int     col;
      ctr = win[1][ccol];
      wet = 1'b0;
      if (ctr == LBL_WATER) return ctr;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          col = ccol + dc;
          if ((dr == 0 && !up_ok) || (dr == 2 && !down_ok)) continue;
          if (dr == 1 && dc == 0) continue;
          if ((dc < 0 && !left_ok) || (dc > 0 && !right_ok)) continue;
          if (col < 0 || col > 2) continue;
          if (win[dr][col] == LBL_WATER) wet = 1'b1;
        end
      end
      return wet ? LBL_SAND : ctr;
    endfunction

    function void note_word(label_t lbl, bit drain);
      int unsigned w, h, c, r, k;
      label_t      n, u, m, res;
      bit          emit, last;
      w    = eff_dim(width_reg, MAX_WIDTH_DEF);
      h    = eff_dim(height_reg, MAX_HEIGHT_DEF);
      c    = in_col;
      r    = in_row;
      emit = 1'b0;
      res  = '0;
      if (c >= w) c = w - 1;
      if (r < h) begin
        if (drain) return;
        n = lbl;
      end else begin
        n = '0;
      end
      // right edge tile of two rows back, window before the shift
      if (c == 0 && r >= 2 && r - 2 < h) begin
        res  = shore_label(2, w >= 2, 1'b0, r >= 3, r - 1 < h);
        emit = 1'b1;
      end
      k = c % MAX_WIDTH_DEF;
      u = upper_line[k];
      m = middle_line[k];
      upper_line[k]  = m;
      middle_line[k] = n;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = u;
      win[1][2] = m;
      win[2][2] = n;
      if (c >= 1 && r >= 1 && r - 1 < h) begin
        res  = shore_label(1, c >= 2, 1'b1, r >= 2, r < h);
        emit = 1'b1;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      in_col = c;
      in_row = r;
      if (!emit) return;
      last = (out_col + 1 >= w) && (out_row + 1 >= h);
      expected_tiles.push_back('{lbl: res, last: last});
      if (last) begin
        restart_map();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_word(label_t lbl, bit last);
      tile_res_t e;
      if (expected_tiles.size() == 0) begin
        if (fail_count < 10) $display("unexpected word: label %0d last %0b", lbl, last);
        fail_count++;
        return;
      end
      e = expected_tiles.pop_front();
      if (e.lbl !== lbl || e.last !== last) begin
        if (fail_count < 10)
          $display("mismatch: exp label %0d last %0b, got label %0d last %0b",
                   e.lbl, e.last, lbl, last);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr_i    = REG_MAP_WIDTH;
  logic [CFG_DW-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [2:0] tile_label
  logic [0:0]          s_axis_tuser  = '0;   // [0] drain
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [2:0] result_label
  logic                m_axis_tlast;

  shore_scoreboard sb = new();
  int unsigned     idle_pct   = 0;
  int unsigned     stall_pct  = 0;
  int unsigned     rand_items = 0;

  water_shore_marking_stencil u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata[2:0], m_axis_tlast);
  end

  function automatic label_t rand_label();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 35) return LBL_WATER;
    if (p < 40) return label_t'($urandom_range(6, 7));
    return label_t'($urandom_range(0, 5));
  endfunction

  task automatic send_word(input label_t lbl, input bit drain);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, lbl};
    s_axis_tuser  <= drain;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(lbl, drain);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_tiles.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_map_size(input bit [CFG_DW-1:0] w, input bit [CFG_DW-1:0] h);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_MAP_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    sb.set_reg(REG_MAP_WIDTH, w);
    cfg_addr_i  <= REG_MAP_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    sb.set_reg(REG_MAP_HEIGHT, h);
    cfg_we_i    <= 1'b0;
  endtask

  // full map plus flush words; stop_at != 0 cuts the map short
  task automatic random_map(input int unsigned w, input int unsigned h,
                            input int unsigned stop_at);
    int unsigned tiles, total;
    tiles = w * h;
    total = tiles + w + 1;
    if (stop_at == 0 || stop_at > total) stop_at = total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (i < tiles && $urandom_range(0, 9) == 0) send_word(rand_label(), 1'b1);
      if (i < tiles) send_word(rand_label(), 1'b0);
      else send_word(rand_label(), 1'($urandom_range(0, 1)));
      rand_items++;
    end
  endtask

  task automatic run_phase(input bit [CFG_DW-1:0] w_reg, input bit [CFG_DW-1:0] h_reg,
                           input int unsigned maps);
    int unsigned w, h, stop_at;
    set_map_size(w_reg, h_reg);
    w = shore_scoreboard::eff_dim(w_reg, MAX_WIDTH_DEF);
    h = shore_scoreboard::eff_dim(h_reg, MAX_HEIGHT_DEF);
    for (int unsigned m = 0; m < maps; m++) begin
      stop_at = 0;
      if (m == maps - 1 && $urandom_range(0, 5) == 0) stop_at = $urandom_range(1, w * h + w);
      random_map(w, h, stop_at);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned start;
    bit [CFG_DW-1:0] w, h;
    start = rand_items;
    while (rand_items - start < n) begin
      w = CFG_DW'($urandom_range(1, 10));
      h = CFG_DW'($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) w = '0;
      if ($urandom_range(0, 9) == 0) h = '0;
      run_phase(w, h, $urandom_range(1, 3));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct  = 17;
    stall_pct = 82;

    // 3x3 map: water in two corners, all label codes, a drain inside the map,
    // tiles after the map are dropped
    set_map_size(CFG_DW'(3), CFG_DW'(3));
    send_word(label_t'(2), 1'b0);
    send_word(label_t'(0), 1'b0);
    send_word(label_t'(1), 1'b0);
    send_word(label_t'(3), 1'b1);
    send_word(label_t'(5), 1'b0);
    send_word(label_t'(7), 1'b0);
    send_word(label_t'(3), 1'b0);
    send_word(label_t'(6), 1'b0);
    send_word(label_t'(4), 1'b0);
    send_word(label_t'(2), 1'b0);
    send_word(label_t'(7), 1'b0);
    send_word(label_t'(3), 1'b0);
    send_word(label_t'(0), 1'b1);
    send_word(label_t'(0), 1'b1);

    // zero size acts as a single tile
    set_map_size('0, '0);
    send_word(label_t'(5), 1'b0);
    send_word(label_t'(0), 1'b1);
    send_word(label_t'(2), 1'b0);

    set_map_size(CFG_DW'(2), CFG_DW'(1));
    send_word(label_t'(3), 1'b0);
    send_word(LBL_WATER, 1'b0);
    send_word(label_t'(0), 1'b1);
    send_word(label_t'(7), 1'b1);
    send_word(label_t'(0), 1'b1);

    // reset-size map, cut short in its second row
    set_map_size(CFG_DW'(DIM_RESET), CFG_DW'(DIM_RESET));
    random_map(DIM_RESET, DIM_RESET, 120);
    run_random(30);

    idle_pct  = 82;
    stall_pct = 17;
    // widest maps, cut short
    set_map_size(11'h7FF, CFG_DW'(1));
    random_map(MAX_WIDTH_DEF, 1, 30);
    set_map_size(CFG_DW'(MAX_WIDTH_DEF), CFG_DW'(2));
    random_map(MAX_WIDTH_DEF, 2, 30);
    run_random(130);

    idle_pct  = 0;
    stall_pct = 0;
    // tallest maps, cut short
    set_map_size(CFG_DW'(1), 11'h7FF);
    random_map(1, MAX_HEIGHT_DEF, 30);
    set_map_size(CFG_DW'(2), CFG_DW'(MAX_HEIGHT_DEF));
    random_map(2, MAX_HEIGHT_DEF, 30);
    run_random(130);

    wait_idle();
    if (sb.fail_count == 0) begin
      $display("[water_shore_marking_stencil] OK");
    end else begin
      $display("[water_shore_marking_stencil] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[water_shore_marking_stencil] ERROR");
    $finish;
  end

endmodule
